// File: src/id_pool_with_local_refcounts_top_assert.svh
// Assertion macros for the id pool top level.
`ifndef ID_POOL_WITH_LOCAL_REFCOUNTS_TOP_ASSERT_SVH
`define ID_POOL_WITH_LOCAL_REFCOUNTS_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define IDP_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("id pool check failed");
`define IDP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("id pool check failed");
`else
`define IDP_ASSERT_IMPLIES(label, ante, cons)
`define IDP_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: src/idp_pkg.sv
// Shared types and constants of the id pool.
`default_nettype none
package idp_pkg;
    localparam int POOL_ENTRIES_DEF = 64;
    localparam int COUNT_WIDTH_DEF  = 32;
    localparam int ID_W       = 6;
    localparam int LINK_W     = 7;
    localparam int OWNER_W    = 32;
    localparam int DELTA_W    = 64;
    localparam int SHIFT_W    = 5;
    localparam int CFG_DATA_W = 32;
    localparam logic [LINK_W-1:0]  LINK_NULL     = 7'd127;
    localparam logic [SHIFT_W-1:0] REF_SHIFT_RST = 5'd2;

    typedef enum logic [2:0] {
        REQ_ASSIGN  = 3'd0,
        REQ_RELEASE = 3'd1,
        REQ_INCREF  = 3'd2,
        REQ_MERGE   = 3'd3,
        REQ_FINAL   = 3'd4
    } t_req;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_IGNORED = 2'd2,
        ST_DIRECT  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_ASSIGN_FIN,
        S_INC_FIN,
        S_MERGE_RD,
        S_MERGE_CHK,
        S_MERGE_END
    } t_state;

    typedef enum logic {
        UOP_INC,
        UOP_SHIFT
    } t_unit_op;

    typedef struct packed {
        logic [ID_W-1:0] addr;
        logic            rd;
        logic            link_we;
        logic            cnt_we;
        logic            own_we;
    } t_tbl_ctrl;

    typedef struct packed {
        t_status            status;
        logic [ID_W-1:0]    id;
        logic               has;
        logic [OWNER_W-1:0] owner;
        logic [DELTA_W-1:0] delta;
        logic               last;
    } t_result;
endpackage
`default_nettype wire

// File: src/idp_unit.sv
// Shared arithmetic unit: saturating counter increment and count shift.
`default_nettype none
module idp_unit #(
    parameter int COUNT_WIDTH = idp_pkg::COUNT_WIDTH_DEF
) (
    input  idp_pkg::t_unit_op              i_op,
    input  logic [COUNT_WIDTH-1:0]         i_a,
    input  logic [idp_pkg::SHIFT_W-1:0]    i_shamt,
    output logic [idp_pkg::DELTA_W-1:0]    o_y
);
    import idp_pkg::*;

    logic [COUNT_WIDTH-1:0] inc_val;

    assign inc_val = (&i_a) ? i_a : i_a + COUNT_WIDTH'(1);

    always_comb begin
        case (i_op)
            UOP_INC:   o_y = DELTA_W'(inc_val);
            UOP_SHIFT: o_y = DELTA_W'(i_a) << i_shamt;
            default:   o_y = '0;
        endcase
    end
endmodule
`default_nettype wire

// File: src/idp_tables.sv
// Link, counter and owner tables, single address, registered reads.
`default_nettype none
module idp_tables #(
    parameter int POOL_ENTRIES = idp_pkg::POOL_ENTRIES_DEF,
    parameter int COUNT_WIDTH  = idp_pkg::COUNT_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  idp_pkg::t_tbl_ctrl            i_ctrl,
    input  logic [idp_pkg::LINK_W-1:0]    i_link_wdata,
    input  logic [COUNT_WIDTH-1:0]        i_cnt_wdata,
    input  logic [idp_pkg::OWNER_W-1:0]   i_own_wdata,
    output logic [idp_pkg::LINK_W-1:0]    o_link_rd,
    output logic [COUNT_WIDTH-1:0]        o_cnt_rd,
    output logic [idp_pkg::OWNER_W-1:0]   o_own_rd
);
    import idp_pkg::*;

    localparam int IDX_W = $clog2(POOL_ENTRIES);

    logic [LINK_W-1:0]      link_mem [POOL_ENTRIES];
    logic [COUNT_WIDTH-1:0] cnt_mem  [POOL_ENTRIES];
    logic [OWNER_W-1:0]     own_mem  [POOL_ENTRIES];
    logic [POOL_ENTRIES-1:0] r_link_vld;
    logic [POOL_ENTRIES-1:0] r_cnt_vld;

    logic [IDX_W-1:0]  addr;
    logic [LINK_W-1:0] link_succ;
    logic [LINK_W-1:0] link_rst_val;

    assign addr = i_ctrl.addr[IDX_W-1:0];
    assign link_succ = LINK_W'(addr) + LINK_W'(1);
    // chain value an entry holds before it is first written
    assign link_rst_val = (link_succ == LINK_W'(POOL_ENTRIES)) ? LINK_NULL : link_succ;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_vld <= '0;
            r_cnt_vld  <= '0;
        end else begin
            if (i_ctrl.link_we) r_link_vld[addr] <= 1'b1;
            if (i_ctrl.cnt_we)  r_cnt_vld[addr]  <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.link_we) link_mem[addr] <= i_link_wdata;
        if (i_ctrl.cnt_we)  cnt_mem[addr]  <= i_cnt_wdata;
        if (i_ctrl.own_we)  own_mem[addr]  <= i_own_wdata;
        if (i_ctrl.rd) begin
            o_link_rd <= r_link_vld[addr] ? link_mem[addr] : link_rst_val;
            o_cnt_rd  <= r_cnt_vld[addr] ? cnt_mem[addr] : '0;
            o_own_rd  <= own_mem[addr];
        end
    end
endmodule
`default_nettype wire

// File: src/id_pool_with_local_refcounts_top.sv
// Top level of the id pool: sequencer, free-list head, config register.
`default_nettype none
`include "id_pool_with_local_refcounts_top_assert.svh"
// Id pool with per-id local reference counters. A request is taken when start is high
// and busy low; each result word is shown for exactly one cycle with o_valid and must
// be taken then, as there is no way to hold it off. Every request yields at least one
// word and the final one carries o_last. Release, rejected and unknown requests pass
// S_DISPATCH only, assign and incref also S_ASSIGN_FIN or S_INC_FIN (the tables have one
// address port with a registered read), merge and finalize S_MERGE_RD and S_MERGE_CHK per
// entry, then S_MERGE_END: each counter is read in S_MERGE_RD, then checked, shifted and
// cleared in S_MERGE_CHK. Merge words come out in increasing id order, at most one per
// entry. Write ref_shift only while busy is low and no word is pending.
module id_pool_with_local_refcounts_top #(
    parameter int POOL_ENTRIES = idp_pkg::POOL_ENTRIES_DEF,
    parameter int COUNT_WIDTH  = idp_pkg::COUNT_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [2:0]                       i_req_type,
    input  logic                             i_id_valid,
    input  logic [idp_pkg::ID_W-1:0]         i_req_id,
    input  logic [idp_pkg::OWNER_W-1:0]      i_owner_handle,
    output logic                             o_valid,
    output logic [1:0]                       o_status,
    output logic [idp_pkg::ID_W-1:0]         o_out_id,
    output logic                             o_has_entry,
    output logic [idp_pkg::OWNER_W-1:0]      o_out_owner,
    output logic [idp_pkg::DELTA_W-1:0]      o_delta,
    output logic                             o_last,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [2:0]                       paddr,
    input  logic [idp_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [idp_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                             pready
);
    import idp_pkg::*;

    localparam int IDX_W = $clog2(POOL_ENTRIES);
    localparam logic CFG_IDX_REF_SHIFT = 1'b0;

    t_state r_state, n_state;
    logic [2:0]             r_req_type;
    logic                   r_has;
    logic [ID_W-1:0]        r_id;
    logic [OWNER_W-1:0]     r_owner;
    logic [LINK_W-1:0]      r_head;
    logic                   r_fin;
    logic [SHIFT_W-1:0]     r_shift;
    logic [IDX_W-1:0]       r_idx;
    logic                   r_pend_vld;
    t_result                r_pend;
    logic                   r_out_vld;
    t_result                r_out;

    t_tbl_ctrl              tc;
    logic [LINK_W-1:0]      link_wdata;
    logic [COUNT_WIDTH-1:0] cnt_wdata;
    logic [LINK_W-1:0]      link_rd;
    logic [COUNT_WIDTH-1:0] cnt_rd;
    logic [OWNER_W-1:0]     own_rd;
    t_unit_op               uop;
    logic [DELTA_W-1:0]     uy;

    logic    accept;
    logic    id_ok;
    logic    pool_empty;
    logic    idx_last;
    logic    cnt_nz;
    logic    e_vld;
    t_result e_res;
    logic    head_we;
    logic [LINK_W-1:0] head_wdata;
    logic    pend_load;
    logic    fin_set;
    logic    cfg_we;

    assign busy       = (r_state != S_IDLE);
    assign accept     = start && !busy;
    assign id_ok      = r_has && (LINK_W'(r_id) < LINK_W'(POOL_ENTRIES));
    assign pool_empty = (r_head >= LINK_W'(POOL_ENTRIES));
    assign idx_last   = (r_idx == IDX_W'(POOL_ENTRIES - 1));
    assign cnt_nz     = (cnt_rd != '0);

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == CFG_IDX_REF_SHIFT);
    assign prdata = (paddr[2] == CFG_IDX_REF_SHIFT) ? CFG_DATA_W'(r_shift) : '0;

    idp_tables #(
        .POOL_ENTRIES (POOL_ENTRIES),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_tables (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (tc),
        .i_link_wdata (link_wdata),
        .i_cnt_wdata  (cnt_wdata),
        .i_own_wdata  (r_owner),
        .o_link_rd    (link_rd),
        .o_cnt_rd     (cnt_rd),
        .o_own_rd     (own_rd)
    );

    idp_unit #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_unit (
        .i_op    (uop),
        .i_a     (cnt_rd),
        .i_shamt (r_shift),
        .o_y     (uy)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:       if (start) n_state = S_DISPATCH;
            S_DISPATCH: begin
                case (r_req_type)
                    REQ_ASSIGN: n_state = pool_empty ? S_IDLE : S_ASSIGN_FIN;
                    REQ_INCREF: n_state = (id_ok && !r_fin) ? S_INC_FIN : S_IDLE;
                    REQ_MERGE,
                    REQ_FINAL:  n_state = S_MERGE_RD;
                    default:    n_state = S_IDLE;
                endcase
            end
            S_ASSIGN_FIN: n_state = S_IDLE;
            S_INC_FIN:    n_state = S_IDLE;
            S_MERGE_RD:   n_state = S_MERGE_CHK;
            S_MERGE_CHK:  n_state = idx_last ? S_MERGE_END : S_MERGE_RD;
            S_MERGE_END:  n_state = S_IDLE;
            default:      n_state = S_IDLE;
        endcase
    end

    always_comb begin
        tc         = '0;
        link_wdata = r_head;
        cnt_wdata  = '0;
        uop        = UOP_SHIFT;
        e_vld      = 1'b0;
        e_res      = '0;
        e_res.last = 1'b1;
        head_we    = 1'b0;
        head_wdata = r_head;
        pend_load  = 1'b0;
        fin_set    = 1'b0;
        case (r_state)
            S_DISPATCH: begin
                case (r_req_type)
                    REQ_ASSIGN: begin
                        if (pool_empty) begin
                            e_vld        = 1'b1;
                            e_res.status = ST_EMPTY;
                        end else begin
                            tc.addr   = r_head[ID_W-1:0];
                            tc.rd     = 1'b1;
                            tc.own_we = 1'b1;
                        end
                    end
                    REQ_RELEASE: begin
                        e_vld    = 1'b1;
                        e_res.id = r_has ? r_id : '0;
                        if (id_ok) begin
                            tc.addr    = r_id;
                            tc.link_we = 1'b1;
                            head_we    = 1'b1;
                            head_wdata = LINK_W'(r_id);
                        end else begin
                            e_res.status = ST_IGNORED;
                        end
                    end
                    REQ_INCREF: begin
                        if (id_ok && !r_fin) begin
                            tc.addr = r_id;
                            tc.rd   = 1'b1;
                        end else begin
                            e_vld        = 1'b1;
                            e_res.status = ST_DIRECT;
                            e_res.id     = r_has ? r_id : '0;
                        end
                    end
                    REQ_MERGE,
                    REQ_FINAL: ;
                    default: begin
                        e_vld        = 1'b1;
                        e_res.status = ST_IGNORED;
                    end
                endcase
            end
            S_ASSIGN_FIN: begin
                e_vld      = 1'b1;
                e_res.id   = r_head[ID_W-1:0];
                head_we    = 1'b1;
                head_wdata = link_rd;
            end
            S_INC_FIN: begin
                uop        = UOP_INC;
                tc.addr    = r_id;
                tc.cnt_we  = 1'b1;
                cnt_wdata  = uy[COUNT_WIDTH-1:0];
                e_vld      = 1'b1;
                e_res.id   = r_id;
            end
            S_MERGE_RD: begin
                tc.addr = ID_W'(r_idx);
                tc.rd   = 1'b1;
            end
            S_MERGE_CHK: begin
                // hold each entry back one hit so the final one can carry last
                if (cnt_nz) begin
                    tc.addr   = ID_W'(r_idx);
                    tc.cnt_we = 1'b1;
                    pend_load = 1'b1;
                    e_vld     = r_pend_vld;
                    e_res     = r_pend;
                end
            end
            S_MERGE_END: begin
                e_vld   = 1'b1;
                fin_set = (r_req_type == REQ_FINAL);
                if (r_pend_vld) begin
                    e_res      = r_pend;
                    e_res.last = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_head     <= '0;
            r_fin      <= 1'b0;
            r_shift    <= REF_SHIFT_RST;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= e_vld;
            if (head_we) r_head <= head_wdata;
            if (fin_set) r_fin <= 1'b1;
            if (cfg_we)  r_shift <= pwdata[SHIFT_W-1:0];
            if (r_state == S_DISPATCH) begin
                r_pend_vld <= 1'b0;
            end else if (pend_load) begin
                r_pend_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req_type <= i_req_type;
            r_has      <= i_id_valid;
            r_id       <= i_req_id;
            r_owner    <= i_owner_handle;
        end
        if (r_state == S_DISPATCH) begin
            r_idx <= '0;
        end else if (r_state == S_MERGE_CHK) begin
            r_idx <= r_idx + IDX_W'(1);
        end
        if (pend_load) begin
            r_pend.status <= ST_OK;
            r_pend.id     <= ID_W'(r_idx);
            r_pend.has    <= 1'b1;
            r_pend.owner  <= own_rd;
            r_pend.delta  <= uy;
            r_pend.last   <= 1'b0;
        end
        if (e_vld) r_out <= e_res;
    end

    assign o_valid     = r_out_vld;
    assign o_status    = r_out.status;
    assign o_out_id    = r_out.id;
    assign o_has_entry = r_out.has;
    assign o_out_owner = r_out.owner;
    assign o_delta     = r_out.delta;
    assign o_last      = r_out.last;

    `IDP_ASSERT_NEXT(a_accept_dispatch, accept, r_state == S_DISPATCH)
    `IDP_ASSERT_IMPLIES(a_word_from_busy, r_out_vld, $past(r_state != S_IDLE))
    `IDP_ASSERT_NEXT(a_fin_sticky, r_fin, r_fin)
    `IDP_ASSERT_IMPLIES(a_entry_ok, r_out_vld && r_out.has, r_out.status == ST_OK)
endmodule
`default_nettype wire

// File: sim/tb_id_pool_with_local_refcounts_top.sv
// Self-checking testbench for the id pool: directed and random requests against a mirror of the pool.
`default_nettype none
module tb_id_pool_with_local_refcounts_top;
    import idp_pkg::*;

    localparam int POOL        = POOL_ENTRIES_DEF;
    localparam int COUNT_W     = COUNT_WIDTH_DEF;
    localparam int STALL_LIMIT = 4000;
    localparam logic [2:0] ADDR_REF_SHIFT = 3'd0;

    typedef enum {MIX_DRAIN, MIX_BALANCED, MIX_RETURN} t_mix;

    typedef struct {
        t_status            status;
        logic [ID_W-1:0]    id;
        logic               has;
        logic [OWNER_W-1:0] owner;
        logic [DELTA_W-1:0] delta;
        logic               last;
    } t_pool_word;

    // Shadow copy of the pool; works out the words each request should produce.
    class id_pool_mirror;
        logic [LINK_W-1:0]  next_link [POOL];
        logic [LINK_W-1:0]  head;
        logic [OWNER_W-1:0] owner_of [POOL];
        logic [COUNT_W-1:0] tally [POOL];
        logic [SHIFT_W-1:0] shift;
        bit                 finalised;
        bit                 owned [POOL];
        bit                 held [POOL];
        t_pool_word         due_words [$];
        int errors, requests, words, merged, empties, shift_writes;

        function new();
            for (int i = 0; i < POOL; i++) begin
                next_link[i] = (i + 1 < POOL) ? LINK_W'(i + 1) : LINK_NULL;
                owner_of[i]  = '0;
                tally[i]     = '0;
                owned[i]     = 1'b0;
                held[i]      = 1'b0;
            end
            head      = '0;
            shift     = REF_SHIFT_RST;
            finalised = 1'b0;
        endfunction

        function void set_ref_shift(logic [SHIFT_W-1:0] value);
            shift = value;
            shift_writes++;
        endfunction

        function void push(t_status st, logic [ID_W-1:0] id, logic has,
                           logic [OWNER_W-1:0] own, logic [DELTA_W-1:0] d, logic last);
            t_pool_word w;
            w.status = st;
            w.id     = id;
            w.has    = has;
            w.owner  = own;
            w.delta  = d;
            w.last   = last;
            due_words.push_back(w);
        endfunction

        function void merge_counters();
            int n;
            n = 0;
            for (int i = 0; i < POOL; i++) begin
                if (tally[i] != '0) begin
                    push(ST_OK, ID_W'(i), 1'b1, owner_of[i], DELTA_W'(tally[i]) << shift, 1'b0);
                    tally[i] = '0;
                    n++;
                end
            end
            merged += n;
            if (n == 0)
                push(ST_OK, '0, 1'b0, '0, '0, 1'b1);
            else
                due_words[due_words.size()-1].last = 1'b1;
        endfunction

        function void note_request(logic [2:0] kind, logic idv, logic [ID_W-1:0] id,
                                   logic [OWNER_W-1:0] own);
            logic [LINK_W-1:0] h;
            logic              id_ok;
            h     = head;
            id_ok = idv && (int'(id) < POOL);
            requests++;
            case (kind)
                REQ_ASSIGN: begin
                    if (int'(h) >= POOL) begin
                        empties++;
                        push(ST_EMPTY, '0, 1'b0, '0, '0, 1'b1);
                    end else begin
                        head        = next_link[h];
                        owner_of[h] = own;
                        owned[h]    = 1'b1;
                        held[h]     = 1'b1;
                        push(ST_OK, h[ID_W-1:0], 1'b0, '0, '0, 1'b1);
                    end
                end
                REQ_RELEASE: begin
                    if (!id_ok) begin
                        push(ST_IGNORED, idv ? id : '0, 1'b0, '0, '0, 1'b1);
                    end else begin
                        next_link[id] = head;
                        head          = LINK_W'(id);
                        held[id]      = 1'b0;
                        push(ST_OK, id, 1'b0, '0, '0, 1'b1);
                    end
                end
                REQ_INCREF: begin
                    if (!id_ok || finalised) begin
                        push(ST_DIRECT, idv ? id : '0, 1'b0, '0, '0, 1'b1);
                    end else begin
                        if (tally[id] != '1)
                            tally[id] = tally[id] + 1'b1;
                        push(ST_OK, id, 1'b0, '0, '0, 1'b1);
                    end
                end
                REQ_MERGE: merge_counters();
                REQ_FINAL: begin
                    merge_counters();
                    finalised = 1'b1;
                end
                default: push(ST_IGNORED, '0, 1'b0, '0, '0, 1'b1);
            endcase
        endfunction

        function void flag(string what, logic [DELTA_W-1:0] exp_v, logic [DELTA_W-1:0] got);
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, exp_v, got);
            errors++;
        endfunction

        function void check_word(logic [1:0] st, logic [ID_W-1:0] id, logic has,
                                 logic [OWNER_W-1:0] own, logic [DELTA_W-1:0] d, logic last);
            t_pool_word w;
            words++;
            if (due_words.size() == 0) begin
                $display("%0t: unexpected word, status %0d id %0d has %0b last %0b",
                         $time, st, id, has, last);
                errors++;
                return;
            end
            w = due_words.pop_front();
            if (st !== w.status)  flag("status", w.status, st);
            if (id !== w.id)      flag("out_id", w.id, id);
            if (has !== w.has)    flag("has_entry", w.has, has);
            if (own !== w.owner)  flag("out_owner", w.owner, own);
            if (d !== w.delta)    flag("delta", w.delta, d);
            if (last !== w.last)  flag("last", w.last, last);
        endfunction

        function int pick_id(bit held_only);
            int ids [$];
            for (int i = 0; i < POOL; i++)
                if (held_only ? held[i] : owned[i])
                    ids.push_back(i);
            if (ids.size() == 0)
                return -1;
            return ids[$urandom_range(0, ids.size() - 1)];
        endfunction
    endclass

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  start          = 1'b0;
    logic [2:0]            i_req_type     = '0;
    logic                  i_id_valid     = 1'b0;
    logic [ID_W-1:0]       i_req_id       = '0;
    logic [OWNER_W-1:0]    i_owner_handle = '0;
    logic                  psel           = 1'b0;
    logic                  penable        = 1'b0;
    logic                  pwrite         = 1'b0;
    logic [2:0]            paddr          = '0;
    logic [CFG_DATA_W-1:0] pwdata         = '0;
    logic                  busy;
    logic                  o_valid;
    logic [1:0]            o_status;
    logic [ID_W-1:0]       o_out_id;
    logic                  o_has_entry;
    logic [OWNER_W-1:0]    o_out_owner;
    logic [DELTA_W-1:0]    o_delta;
    logic                  o_last;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    id_pool_mirror mirror;
    bit            steady = 1'b0;
    int            quiet_cycles = 0;

    id_pool_with_local_refcounts_top i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_req_type     (i_req_type),
        .i_id_valid     (i_id_valid),
        .i_req_id       (i_req_id),
        .i_owner_handle (i_owner_handle),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_out_id       (o_out_id),
        .o_has_entry    (o_has_entry),
        .o_out_owner    (o_out_owner),
        .o_delta        (o_delta),
        .o_last         (o_last),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid)
                mirror.check_word(o_status, o_out_id, o_has_entry, o_out_owner, o_delta, o_last);
            if (start && !busy)
                mirror.note_request(i_req_type, i_id_valid, i_req_id, i_owner_handle);
            if (psel && penable && pwrite && pready && paddr == ADDR_REF_SHIFT)
                mirror.set_ref_shift(pwdata[SHIFT_W-1:0]);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || o_valid || (start && !busy) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after the request is taken,
    // leaving start high so the next call can keep it there without a dip.
    // Outside the steady stretch start drops while busy, then idles at random.
    task automatic issue(input logic [2:0] kind, input logic idv, input logic [ID_W-1:0] id,
                         input logic [OWNER_W-1:0] own);
        while (!steady && (busy || $urandom_range(0, 99) < 28)) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start          <= 1'b1;
        i_req_type     <= kind;
        i_id_valid     <= idv;
        i_req_id       <= id;
        i_owner_handle <= own;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic settle();
        start <= 1'b0;
        @(negedge i_clk);
        while (mirror.due_words.size() != 0 || busy) @(negedge i_clk);
    endtask

    // write, then read back
    task automatic write_reg(input logic [2:0] addr, input logic [CFG_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== CFG_DATA_W'(value[SHIFT_W-1:0]))
            mirror.flag("prdata", DELTA_W'(value[SHIFT_W-1:0]), DELTA_W'(prdata));
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic random_item(input t_mix mix);
        int              roll;
        int              sel;
        logic [2:0]      kind;
        logic            idv;
        logic [ID_W-1:0] id;
        roll = $urandom_range(0, 99);
        idv  = 1'b1;
        id   = ID_W'($urandom_range(0, POOL - 1));
        case (mix)
            MIX_DRAIN:
                kind = roll < 90 ? REQ_ASSIGN : roll < 95 ? REQ_INCREF : REQ_RELEASE;
            MIX_BALANCED:
                kind = roll < 25 ? REQ_ASSIGN : roll < 50 ? REQ_RELEASE :
                       roll < 88 ? REQ_INCREF : roll < 96 ? REQ_MERGE :
                       3'($urandom_range(5, 7));
            default:
                kind = roll < 20 ? REQ_ASSIGN : roll < 65 ? REQ_RELEASE :
                       roll < 92 ? REQ_INCREF : REQ_MERGE;
        endcase
        roll = $urandom_range(0, 99);
        if (kind == REQ_RELEASE) begin
            // draining keeps releases well formed so the free list stays a chain
            sel = mirror.pick_id(1'b1);
            if (mix != MIX_DRAIN && roll < 10)
                idv = 1'b0;
            else if ((mix != MIX_DRAIN && roll < 20) || sel < 0)
                idv = (mix != MIX_DRAIN) || sel >= 0;
            else
                id = ID_W'(sel);
        end else if (kind == REQ_INCREF) begin
            // counted ids must have had an owner written
            sel = roll < 70 ? mirror.pick_id(1'b1) : mirror.pick_id(1'b0);
            if (sel < 0)
                sel = mirror.pick_id(1'b0);
            if (roll >= 90 || sel < 0)
                idv = 1'b0;
            else
                id = ID_W'(sel);
        end else if (kind != REQ_ASSIGN) begin
            idv = 1'($urandom_range(0, 1));
        end
        issue(kind, idv, id, $urandom);
    endtask

    initial begin
        logic [SHIFT_W-1:0] shift_plan [8];
        int                 sel;
        int                 span;
        t_mix               mix;

        mirror = new();
        shift_plan = '{5'd0, 5'd31, 5'd0, 5'd17, 5'd1, 5'd0, 5'd31, 5'd2};
        shift_plan[2] = SHIFT_W'($urandom);
        shift_plan[5] = SHIFT_W'($urandom);

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty merge, requests without id, first assigns, counting, reuse
        issue(REQ_MERGE, 1'b0, '0, '0);
        issue(REQ_INCREF, 1'b0, 6'd63, '0);
        issue(REQ_RELEASE, 1'b0, 6'd63, 32'hFFFF_FFFF);
        issue(REQ_ASSIGN, 1'b0, '0, 32'h0000_0000);
        issue(REQ_ASSIGN, 1'b1, 6'd63, 32'hFFFF_FFFF);
        issue(REQ_ASSIGN, 1'b0, '0, 32'h5A5A_A5A5);
        issue(REQ_INCREF, 1'b1, 6'd0, '0);
        issue(REQ_INCREF, 1'b1, 6'd0, 32'hFFFF_FFFF);
        issue(REQ_INCREF, 1'b1, 6'd1, '0);
        issue(REQ_INCREF, 1'b1, 6'd2, '0);
        issue(REQ_RELEASE, 1'b1, 6'd1, '0);
        issue(REQ_ASSIGN, 1'b0, '0, 32'h8000_0001);
        issue(REQ_INCREF, 1'b1, 6'd1, '0);
        issue(3'd5, 1'b1, 6'd63, $urandom);
        issue(3'd6, 1'b0, 6'd42, $urandom);
        issue(3'd7, 1'b1, 6'd21, $urandom);
        issue(REQ_MERGE, 1'b1, 6'd63, $urandom);
        issue(REQ_MERGE, 1'b0, '0, '0);
        settle();
        write_reg(ADDR_REF_SHIFT, {27'h7FF_FFFF, 5'd31});
        issue(REQ_INCREF, 1'b1, 6'd0, '0);
        issue(REQ_INCREF, 1'b1, 6'd2, '0);
        issue(REQ_MERGE, 1'b0, '0, '0);

        // random phases, each closed by a merge and followed by a new shift
        for (int p = 0; p < 8; p++) begin
            settle();
            write_reg(ADDR_REF_SHIFT, {27'($urandom), shift_plan[p]});
            mix    = p == 0 ? MIX_DRAIN : (p % 3 == 2 ? MIX_RETURN : MIX_BALANCED);
            span   = p == 0 ? 90 : 38;
            steady = (p == 3);
            for (int k = 0; k < span; k++)
                random_item(mix);
            issue(REQ_MERGE, 1'b0, '0, $urandom);
        end
        steady = 1'b0;

        // finalise: counting stops for good and later increfs go direct
        settle();
        write_reg(ADDR_REF_SHIFT, {27'($urandom), 5'($urandom)});
        sel = mirror.pick_id(1'b0);
        issue(REQ_INCREF, 1'b1, ID_W'(sel), '0);
        issue(REQ_INCREF, 1'b1, ID_W'(mirror.pick_id(1'b0)), '0);
        issue(REQ_FINAL, 1'b0, '0, '0);
        issue(REQ_INCREF, 1'b1, ID_W'(sel), '0);
        issue(REQ_INCREF, 1'b0, 6'd63, '0);
        issue(REQ_MERGE, 1'b0, '0, '0);
        issue(REQ_FINAL, 1'b1, 6'd63, '0);
        issue(REQ_ASSIGN, 1'b0, '0, $urandom);
        issue(REQ_RELEASE, 1'b1, ID_W'(sel), '0);
        settle();
        repeat (2 * POOL + 8) @(posedge i_clk);

        $display("covered %0d requests and %0d result words, %0d of them merged counters",
                 mirror.requests, mirror.words, mirror.merged);
        $display("pool ran dry on %0d assigns; ref_shift written %0d times",
                 mirror.empties, mirror.shift_writes);
        if (mirror.errors == 0 && mirror.due_words.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
`default_nettype wire
